// File: hdl/lidar_scan_packet_decoder_core_assert.svh
// Assertion macros for the scan packet decoder.
// Each macro takes a label, a condition and a consequence.
// All of them sample on clk and are held off while rst_n is low.
`ifndef LIDAR_SCAN_PACKET_DECODER_CORE_ASSERT_SVH
`define LIDAR_SCAN_PACKET_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LSPD_ASSERT_SAME(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("lspd: same-cycle check failed");
`define LSPD_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("lspd: next-cycle check failed");
`else
`define LSPD_ASSERT_SAME(lbl, cond, conseq)
`define LSPD_ASSERT_NEXT(lbl, cond, conseq)
`endif
`endif

// File: hdl/lspd_pkg.sv
// ----------------------------------------------------------------------------
// Scan packet decoder package
// Types, widths and codes shared by the decoder modules and interfaces.
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam int ANGLE_BINS  = 360;
    localparam int PKT_BYTES   = 5;
    localparam int HDR_BYTES   = PKT_BYTES - 1;
    localparam int POS_W       = $clog2(PKT_BYTES);
    localparam int BYTE_W      = 8;
    localparam int BIN_W       = 9;
    localparam int DIST_W      = 14;
    localparam int QUAL_W      = 6;
    localparam int ANGLE_W     = 15;
    localparam int ANGLE_FRAC  = 6;
    localparam int ANGLE_ROUND = 1 << (ANGLE_FRAC - 1);
    localparam int ENTRY_W     = DIST_W + QUAL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_RX_BYTE = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CMD_READ = 2'd0,
        CMD_GOOD = 2'd1,
        CMD_BAD  = 2'd2
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t           kind;
        logic [BIN_W-1:0]    bin;
        logic [DIST_W-1:0]   dist_mm;
        logic [QUAL_W-1:0]   qual;
        logic                start;
        logic                rst_req;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hdl/lspd_if.sv
// ----------------------------------------------------------------------------
// Scan packet decoder channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface lspd_in_if import lspd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [BYTE_W-1:0]  rx_byte;
    logic [BIN_W-1:0]   read_bin;

    modport source (output valid, operation, rx_byte, read_bin, input ready);
    modport sink (input valid, operation, rx_byte, read_bin, output ready);
endinterface

interface lspd_out_if import lspd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               is_read_reply;
    logic [BIN_W-1:0]   angle_bin;
    logic [DIST_W-1:0]  distance_mm;
    logic [QUAL_W-1:0]  sample_quality;
    logic               scan_start;
    logic               packet_bad;
    logic               reset_request;

    modport source (output valid, is_read_reply, angle_bin, distance_mm, sample_quality,
                    scan_start, packet_bad, reset_request, input ready);
    modport sink (input valid, is_read_reply, angle_bin, distance_mm, sample_quality,
                  scan_start, packet_bad, reset_request, output ready);
endinterface

// File: hdl/lspd_front.sv
// ----------------------------------------------------------------------------
// Scan packet decoder front end
// Assembles bytes into packets, checks the start bits and issues commands.
// ----------------------------------------------------------------------------
module lspd_front
    import lspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lspd_in_if.sink     item,
    input  logic        can_take,
    output logic        push,
    output cmd_t        cmd
);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [BYTE_W-1:0]  bytes_reg [HDR_BYTES];
    logic               req_sent_reg;
    logic               req_sent_next;

    logic               accept;
    logic               is_read;
    logic               last_byte;
    logic               bad;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W:0]   angle_sum;
    logic [ANGLE_W-ANGLE_FRAC:0] deg;
    logic [ANGLE_W-ANGLE_FRAC:0] deg_wrapped;
    logic [2*BYTE_W-1:0] dist_raw;

    assign item.ready = can_take;
    assign accept     = item.valid && item.ready;
    assign is_read    = op_t'(item.operation) == OP_READ;
    assign last_byte  = pos_reg == POS_W'(HDR_BYTES);

    // The start bit and its inverse must differ in a good packet.
    assign bad       = bytes_reg[0][0] == bytes_reg[0][1];
    assign angle     = {bytes_reg[2], bytes_reg[1][BYTE_W-1:1]};
    assign angle_sum = {1'b0, angle} + (ANGLE_W+1)'(ANGLE_ROUND);
    assign deg       = angle_sum[ANGLE_W:ANGLE_FRAC];
    // The rounded degree never reaches twice the bin count.
    assign deg_wrapped = (deg >= (ANGLE_W-ANGLE_FRAC+1)'(ANGLE_BINS))
                       ? deg - (ANGLE_W-ANGLE_FRAC+1)'(ANGLE_BINS) : deg;
    assign dist_raw  = {item.rx_byte, bytes_reg[3]};

    assign push = accept && (is_read || last_byte);

    always_comb
    begin
        cmd           = '0;
        pos_next      = pos_reg;
        req_sent_next = req_sent_reg;
        if (is_read)
        begin
            cmd.kind = CMD_READ;
            cmd.bin  = item.read_bin;
        end
        else if (bad)
        begin
            cmd.kind      = CMD_BAD;
            cmd.rst_req   = !req_sent_reg;
        end
        else
        begin
            cmd.kind    = CMD_GOOD;
            cmd.bin     = deg_wrapped[BIN_W-1:0];
            cmd.dist_mm = dist_raw[2*BYTE_W-1:2];
            cmd.qual    = bytes_reg[0][BYTE_W-1:2];
            cmd.start   = bytes_reg[0][0];
        end
        if (accept && !is_read)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                if (bad)
                begin
                    req_sent_next = 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            req_sent_reg <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                bytes_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg      <= pos_next;
            req_sent_reg <= req_sent_next;
            if (accept && !is_read && !last_byte)
            begin
                bytes_reg[pos_reg[1:0]] <= item.rx_byte;
            end
        end
    end

endmodule

// File: hdl/lspd_queue.sv
// ----------------------------------------------------------------------------
// Scan packet decoder command queue
// Short FIFO between the front end and the table back end.
// ----------------------------------------------------------------------------
module lspd_queue
    import lspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_cmd,
    input  logic        pop,
    output cmd_t        head,
    output q_status_t   status
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/lspd_back.sv
// ----------------------------------------------------------------------------
// Scan packet decoder back end
// Holds the per-degree table, runs commands and drives the result register.
// ----------------------------------------------------------------------------
module lspd_back
    import lspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        clearing,
    lspd_out_if.source  result
);

    logic [ENTRY_W-1:0] table_mem [ANGLE_BINS];
    logic               clr_active_reg;
    logic [BIN_W-1:0]   clr_idx_reg;
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic               s1_hit_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               in_range;
    logic               advance;

    assign clearing = clr_active_reg;
    assign in_range = head.bin < BIN_W'(ANGLE_BINS);
    assign advance  = !s1_valid_reg || result.ready;
    assign pop      = !q_status.empty && !clr_active_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_idx_reg == BIN_W'(ANGLE_BINS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (advance)
            begin
                s1_valid_reg <= pop;
            end
        end
    end

    // A table write and a table read never come from the same beat, so a
    // read that follows a write to the same bin sees the new entry.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            table_mem[clr_idx_reg] <= '0;
        end
        else if (pop && head.kind == CMD_GOOD)
        begin
            table_mem[head.bin] <= {head.dist_mm, head.qual};
        end
        if (pop && head.kind == CMD_READ && in_range)
        begin
            rd_data_reg <= table_mem[head.bin];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg <= head;
            s1_hit_reg <= in_range;
        end
    end

    always_comb
    begin
        result.valid          = s1_valid_reg;
        result.is_read_reply  = 1'b0;
        result.angle_bin      = s1_cmd_reg.bin;
        result.distance_mm    = s1_cmd_reg.dist_mm;
        result.sample_quality = s1_cmd_reg.qual;
        result.scan_start     = s1_cmd_reg.start;
        result.packet_bad     = 1'b0;
        result.reset_request  = s1_cmd_reg.rst_req;
        unique case (s1_cmd_reg.kind)
            CMD_READ:
            begin
                result.is_read_reply  = 1'b1;
                result.distance_mm    = s1_hit_reg ? rd_data_reg[ENTRY_W-1:QUAL_W] : '0;
                result.sample_quality = s1_hit_reg ? rd_data_reg[QUAL_W-1:0] : '0;
            end
            CMD_GOOD:
            begin
                result.is_read_reply = 1'b0;
            end
            CMD_BAD:
            begin
                result.packet_bad = 1'b1;
            end
            default:
            begin
                result.angle_bin      = '0;
                result.distance_mm    = '0;
                result.sample_quality = '0;
                result.scan_start     = 1'b0;
                result.reset_request  = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/lidar_scan_packet_decoder_core.sv
// A packet's fifth byte or a read goes into the command queue, then into the result register.
// Throughput: one input beat per cycle while result.ready holds, set by the single write or
// read port of the bin table. Bytes that do not end a packet give no result.
// Reset: rst_n is asynchronous; afterwards a pass zeroes the bin table, one entry a cycle, and
// no input beat is taken until it ends.
// ----------------------------------------------------------------------------
// Scan packet decoder top level
// Front end, command queue and table back end of the sample packet decoder.
// ----------------------------------------------------------------------------
`include "lidar_scan_packet_decoder_core_assert.svh"

module lidar_scan_packet_decoder_core
    import lspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lspd_in_if.sink     item,
    lspd_out_if.source  result
);

    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       head;
    q_status_t  q_stat;
    logic       clearing;
    logic       can_take;

    assign can_take = !q_stat.full && !clearing;

    lspd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .can_take (can_take),
        .push     (push),
        .cmd      (push_cmd)
    );

    lspd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_stat)
    );

    lspd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_stat),
        .pop      (pop),
        .clearing (clearing),
        .result   (result)
    );

    `LSPD_ASSERT_SAME(a_no_push_when_full, q_stat.full, !push)
    `LSPD_ASSERT_SAME(a_idle_while_clearing, clearing, q_stat.empty && !result.valid && !pop)
    `LSPD_ASSERT_SAME(a_req_only_on_bad, result.valid && result.reset_request, result.packet_bad)
    `LSPD_ASSERT_NEXT(a_pop_gives_result, pop, result.valid)

endmodule
